// ===== sv/wsp_pkg.sv =====
`default_nettype none
package wsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_SLOTS    = 12;
  localparam int IDX_W         = 4;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int DIM_W         = 14;
  localparam int CAP_LOG       = 40;
  localparam int QW            = CAP_LOG + 1;
  localparam int ROWS          = 3;
  localparam int COLS          = 4;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic visible;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } proj_ctl_t;

endpackage
`default_nettype wire

// ===== sv/wsp_if.sv =====
`default_nettype none
interface wsp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [wsp_pkg::IDX_W-1:0]           coef_index;
  logic signed [wsp_pkg::DATA_W-1:0]   coef_value;
  logic signed [wsp_pkg::DATA_W-1:0]   point_x;
  logic signed [wsp_pkg::DATA_W-1:0]   point_y;
  logic signed [wsp_pkg::DATA_W-1:0]   point_z;

  modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface wsp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                visible;
  logic signed [wsp_pkg::DATA_W-1:0]   screen_x;
  logic signed [wsp_pkg::DATA_W-1:0]   screen_y;

  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface
`default_nettype wire

// ===== sv/wsp_dot.sv =====
`default_nettype none
module wsp_dot #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF,
  parameter int SW        = 66 - FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               en0_i,
  input  wire logic                               en1_i,
  input  wire logic signed [wsp_pkg::DATA_W-1:0]  coef_i [wsp_pkg::COEF_SLOTS],
  input  wire logic signed [wsp_pkg::DATA_W-1:0]  point_x_i,
  input  wire logic signed [wsp_pkg::DATA_W-1:0]  point_y_i,
  input  wire logic signed [wsp_pkg::DATA_W-1:0]  point_z_i,
  output logic signed [SW-1:0]                    clip_o [wsp_pkg::ROWS]
);

  localparam int NP = wsp_pkg::ROWS * (wsp_pkg::COLS - 1);

  logic signed [wsp_pkg::DATA_W-1:0] pt [wsp_pkg::COLS-1];
  logic signed [wsp_pkg::PROD_W-1:0] prod_d [NP];
  logic signed [wsp_pkg::PROD_W-1:0] prod_q [NP];
  logic signed [wsp_pkg::DATA_W-1:0] bias_q [wsp_pkg::ROWS];
  logic signed [wsp_pkg::PROD_W-1:0] shf [NP];
  logic signed [SW-1:0]              term [NP];
  logic signed [SW-1:0]              clip_d [wsp_pkg::ROWS];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_comb begin
    for (int g = 0; g < wsp_pkg::ROWS; g++) begin
      for (int c = 0; c < wsp_pkg::COLS - 1; c++) begin
        prod_d[g*3+c] = wsp_pkg::PROD_W'(coef_i[g*wsp_pkg::COLS+c])
                      * wsp_pkg::PROD_W'(pt[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0_i) begin
      prod_q <= prod_d;
      for (int g = 0; g < wsp_pkg::ROWS; g++) begin
        bias_q[g] <= coef_i[g*wsp_pkg::COLS + wsp_pkg::COLS - 1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      shf[i]  = prod_q[i] >>> FRAC_BITS;
      term[i] = shf[i][SW-1:0];
    end
    for (int g = 0; g < wsp_pkg::ROWS; g++) begin
      clip_d[g] = term[g*3] + term[g*3+1] + term[g*3+2]
                + {{(SW-wsp_pkg::DATA_W){bias_q[g][wsp_pkg::DATA_W-1]}}, bias_q[g]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      clip_o <= clip_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/wsp_scale.sv =====
`default_nettype none
module wsp_scale #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF,
  parameter int SW        = 66 - FRAC_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         en0_i,
  input  wire logic                         en1_i,
  input  wire logic signed [SW-1:0]         clip_i [wsp_pkg::ROWS],
  input  wire logic [wsp_pkg::DIM_W-1:0]    width_i,
  input  wire logic [wsp_pkg::DIM_W-1:0]    height_i,
  output logic [SW:0]                       div_o,
  output logic [SW:0]                       rem_x_o,
  output logic [SW:0]                       rem_y_o,
  output logic [wsp_pkg::QW-1:0]            low_x_o,
  output logic [wsp_pkg::QW-1:0]            low_y_o,
  output wsp_pkg::proj_ctl_t                ctl_o
);

  localparam int MW   = SW + wsp_pkg::DIM_W;
  localparam int NW   = MW + FRAC_BITS;
  localparam int HW   = NW - wsp_pkg::QW;
  localparam int CMPW = (HW > SW + 1) ? HW : SW + 1;
  localparam logic signed [SW-1:0] THRESH = SW'((64'd1 << FRAC_BITS) / 64'd100);

  logic [SW-1:0]       abs_x, abs_y;
  logic [MW-1:0]       mag_x_q, mag_y_q;
  logic [SW:0]         div_q;
  logic                vis_q, neg_x_q, neg_y_q;
  logic [NW-1:0]       num_x, num_y;
  logic [CMPW-1:0]     hi_x, hi_y, div_ext;
  logic                sat_x, sat_y;

  assign abs_x = clip_i[0][SW-1] ? SW'(-clip_i[0]) : SW'(clip_i[0]);
  assign abs_y = clip_i[1][SW-1] ? SW'(-clip_i[1]) : SW'(clip_i[1]);

  always_ff @(posedge clk_i) begin
    if (en0_i) begin
      mag_x_q <= MW'(abs_x) * MW'(width_i);
      mag_y_q <= MW'(abs_y) * MW'(height_i);
      div_q   <= {clip_i[2], 1'b0};
      vis_q   <= (clip_i[2] >= THRESH);
      neg_x_q <= clip_i[0][SW-1];
      neg_y_q <= clip_i[1][SW-1];
    end
  end

  assign num_x   = {mag_x_q, {FRAC_BITS{1'b0}}};
  assign num_y   = {mag_y_q, {FRAC_BITS{1'b0}}};
  assign hi_x    = CMPW'(num_x[NW-1:wsp_pkg::QW]);
  assign hi_y    = CMPW'(num_y[NW-1:wsp_pkg::QW]);
  assign div_ext = CMPW'(div_q);
  assign sat_x   = hi_x >= div_ext;
  assign sat_y   = hi_y >= div_ext;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      div_o         <= div_q;
      rem_x_o       <= sat_x ? '0 : hi_x[SW:0];
      rem_y_o       <= sat_y ? '0 : hi_y[SW:0];
      low_x_o       <= num_x[wsp_pkg::QW-1:0];
      low_y_o       <= num_y[wsp_pkg::QW-1:0];
      ctl_o.visible <= vis_q;
      ctl_o.neg_x   <= neg_x_q;
      ctl_o.neg_y   <= neg_y_q;
      ctl_o.sat_x   <= sat_x;
      ctl_o.sat_y   <= sat_y;
    end
  end

endmodule
`default_nettype wire

// ===== sv/wsp_div.sv =====
`default_nettype none
module wsp_div #(
  parameter int SW = 50
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [SW:0]                 div_i,
  input  wire logic [SW:0]                 rem_x_i,
  input  wire logic [SW:0]                 rem_y_i,
  input  wire logic [wsp_pkg::QW-1:0]      low_x_i,
  input  wire logic [wsp_pkg::QW-1:0]      low_y_i,
  input  wire logic [wsp_pkg::QW-1:0]      q_x_i,
  input  wire logic [wsp_pkg::QW-1:0]      q_y_i,
  input  wire wsp_pkg::proj_ctl_t          ctl_i,
  output logic [SW:0]                      div_o,
  output logic [SW:0]                      rem_x_o,
  output logic [SW:0]                      rem_y_o,
  output logic [wsp_pkg::QW-1:0]           low_x_o,
  output logic [wsp_pkg::QW-1:0]           low_y_o,
  output logic [wsp_pkg::QW-1:0]           q_x_o,
  output logic [wsp_pkg::QW-1:0]           q_y_o,
  output wsp_pkg::proj_ctl_t               ctl_o
);

  logic [SW+1:0] sh_x, sh_y, dx;
  logic          ge_x, ge_y;
  logic [SW+1:0] dif_x, dif_y;

  assign dx    = {1'b0, div_i};
  assign sh_x  = {rem_x_i, low_x_i[wsp_pkg::QW-1]};
  assign sh_y  = {rem_y_i, low_y_i[wsp_pkg::QW-1]};
  assign ge_x  = sh_x >= dx;
  assign ge_y  = sh_y >= dx;
  assign dif_x = sh_x - dx;
  assign dif_y = sh_y - dx;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o   <= div_i;
      rem_x_o <= ge_x ? dif_x[SW:0] : sh_x[SW:0];
      rem_y_o <= ge_y ? dif_y[SW:0] : sh_y[SW:0];
      low_x_o <= {low_x_i[wsp_pkg::QW-2:0], 1'b0};
      low_y_o <= {low_y_i[wsp_pkg::QW-2:0], 1'b0};
      q_x_o   <= {q_x_i[wsp_pkg::QW-2:0], ge_x};
      q_y_o   <= {q_y_i[wsp_pkg::QW-2:0], ge_y};
      ctl_o   <= ctl_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/world_to_screen_projection_core.sv =====
`default_nettype none
// Results pass the dot-product, scale, restoring divider and output registers in order.
// Throughput: one item per cycle unless the output stalls; 41 divider steps set the depth.
// Load items with index below 12 update the matrix at acceptance; none gives a result.
// Reset clears all coefficients, sets width 1920 and height 1080, and empties the pipeline.
module world_to_screen_projection_core #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  wsp_in_if.sink                          in_if,
  wsp_out_if.source                       out_if,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [wsp_pkg::DIM_W-1:0]  cfg_wdata_i
);

  localparam int SW  = 66 - FRAC_BITS;
  localparam int ND  = wsp_pkg::QW;
  localparam int NS  = 4 + ND + 1;
  localparam int OUT = NS - 1;
  localparam logic [wsp_pkg::QW-1:0] QCAP = wsp_pkg::QW'(1) << wsp_pkg::CAP_LOG;
  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;
  logic          accept;

  logic signed [wsp_pkg::DATA_W-1:0] coef_q [wsp_pkg::COEF_SLOTS];
  logic [wsp_pkg::DIM_W-1:0]         width_q, height_q;

  logic signed [SW-1:0] clip [wsp_pkg::ROWS];

  logic [SW:0]              div_s   [ND+1];
  logic [SW:0]              rem_x_s [ND+1];
  logic [SW:0]              rem_y_s [ND+1];
  logic [wsp_pkg::QW-1:0]   low_x_s [ND+1];
  logic [wsp_pkg::QW-1:0]   low_y_s [ND+1];
  logic [wsp_pkg::QW-1:0]   q_x_s   [ND+1];
  logic [wsp_pkg::QW-1:0]   q_y_s   [ND+1];
  wsp_pkg::proj_ctl_t       ctl_s   [ND+1];

  logic [wsp_pkg::QW-1:0]   mag_x, mag_y;
  logic signed [63:0]       off_x, off_y, ctr_x, ctr_y, sum_x, sum_y;
  logic signed [63:0]       sx_d, sy_d;
  logic                     vis_q;
  logic signed [wsp_pkg::DATA_W-1:0] sx_q, sy_q;

  always_comb begin
    rdy[NS] = out_if.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_if.ready = rdy[0];
  assign accept      = in_if.valid && rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= accept && (in_if.op == wsp_pkg::OP_PROJECT);
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wsp_pkg::COEF_SLOTS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (accept && (in_if.op == wsp_pkg::OP_LOAD)
                 && (in_if.coef_index < wsp_pkg::IDX_W'(wsp_pkg::COEF_SLOTS))) begin
      coef_q[in_if.coef_index] <= in_if.coef_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wsp_pkg::WIDTH_RST;
      height_q <= wsp_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wsp_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        wsp_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  wsp_dot #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_dot (
    .clk_i     (clk_i),
    .en0_i     (rdy[0]),
    .en1_i     (rdy[1]),
    .coef_i    (coef_q),
    .point_x_i (in_if.point_x),
    .point_y_i (in_if.point_y),
    .point_z_i (in_if.point_z),
    .clip_o    (clip)
  );

  wsp_scale #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_scale (
    .clk_i    (clk_i),
    .en0_i    (rdy[2]),
    .en1_i    (rdy[3]),
    .clip_i   (clip),
    .width_i  (width_q),
    .height_i (height_q),
    .div_o    (div_s[0]),
    .rem_x_o  (rem_x_s[0]),
    .rem_y_o  (rem_y_s[0]),
    .low_x_o  (low_x_s[0]),
    .low_y_o  (low_y_s[0]),
    .ctl_o    (ctl_s[0])
  );

  assign q_x_s[0] = '0;
  assign q_y_s[0] = '0;

  for (genvar i = 0; i < ND; i++) begin : g_div
    wsp_div #(.SW(SW)) u_div (
      .clk_i   (clk_i),
      .en_i    (rdy[4+i]),
      .div_i   (div_s[i]),
      .rem_x_i (rem_x_s[i]),
      .rem_y_i (rem_y_s[i]),
      .low_x_i (low_x_s[i]),
      .low_y_i (low_y_s[i]),
      .q_x_i   (q_x_s[i]),
      .q_y_i   (q_y_s[i]),
      .ctl_i   (ctl_s[i]),
      .div_o   (div_s[i+1]),
      .rem_x_o (rem_x_s[i+1]),
      .rem_y_o (rem_y_s[i+1]),
      .low_x_o (low_x_s[i+1]),
      .low_y_o (low_y_s[i+1]),
      .q_x_o   (q_x_s[i+1]),
      .q_y_o   (q_y_s[i+1]),
      .ctl_o   (ctl_s[i+1])
    );
  end

  always_comb begin
    mag_x = (ctl_s[ND].sat_x || (q_x_s[ND] > QCAP)) ? QCAP : q_x_s[ND];
    mag_y = (ctl_s[ND].sat_y || (q_y_s[ND] > QCAP)) ? QCAP : q_y_s[ND];
    off_x = ctl_s[ND].neg_x ? -$signed(64'(mag_x)) : $signed(64'(mag_x));
    off_y = ctl_s[ND].neg_y ? -$signed(64'(mag_y)) : $signed(64'(mag_y));
    ctr_x = $signed(64'(width_q)  << (FRAC_BITS - 1));
    ctr_y = $signed(64'(height_q) << (FRAC_BITS - 1));
    sum_x = ctr_x + off_x;
    sum_y = ctr_y - off_y;
    sx_d  = (sum_x > SMAX) ? SMAX : ((sum_x < SMIN) ? SMIN : sum_x);
    sy_d  = (sum_y > SMAX) ? SMAX : ((sum_y < SMIN) ? SMIN : sum_y);
    if (!ctl_s[ND].visible) begin
      sx_d = '0;
      sy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OUT]) begin
      vis_q <= ctl_s[ND].visible;
      sx_q  <= sx_d[wsp_pkg::DATA_W-1:0];
      sy_q  <= sy_d[wsp_pkg::DATA_W-1:0];
    end
  end

  assign out_if.valid    = v_q[OUT];
  assign out_if.visible  = vis_q;
  assign out_if.screen_x = sx_q;
  assign out_if.screen_y = sy_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.visible |-> out_if.screen_x == '0 && out_if.screen_y == '0)
    else $error("rejected point with nonzero coordinates");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input held off without a blocked result");

  a_project_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && (in_if.op == wsp_pkg::OP_PROJECT) |=> v_q[0])
    else $error("project item lost at entry");

  a_load_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && (in_if.op == wsp_pkg::OP_LOAD) |=> !v_q[0])
    else $error("load item entered the pipeline");

endmodule
`default_nettype wire
